FILE: hdl/cancs_pkg.sv
// Types and constants shared by the CAN controller SPI frame sequencer.
package cancs_pkg;

   localparam int BURST_LEN = 13;

   // Result kinds
   localparam logic [1:0] KIND_SPI = 2'd0;
   localparam logic [1:0] KIND_TX  = 2'd1;
   localparam logic [1:0] KIND_RX  = 2'd2;

   // Request types
   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_POLL = 2'd1;
   localparam logic [1:0] REQ_BYTE = 2'd2;

   // Controller instructions and register addresses
   localparam logic [7:0] INS_WRITE  = 8'h02;
   localparam logic [7:0] INS_READ   = 8'h03;
   localparam logic [7:0] INS_BITMOD = 8'h05;
   localparam logic [7:0] INS_RTS0   = 8'h81;
   localparam logic [7:0] INS_RXB0   = 8'h90;
   localparam logic [7:0] INS_RXB1   = 8'h96;
   localparam logic [7:0] REG_INTF   = 8'h2C;
   localparam logic [7:0] REG_TXCTRL = 8'h30;
   localparam logic [7:0] REG_TXSIDH = 8'h31;
   localparam int         TXREQ_BIT  = 2;

   // Commands handed from front to back
   localparam logic [2:0] CMD_TX_READ  = 3'd0;
   localparam logic [2:0] CMD_RX_READ  = 3'd1;
   localparam logic [2:0] CMD_TX_BUSY  = 3'd2;
   localparam logic [2:0] CMD_TX_WRITE = 3'd3;
   localparam logic [2:0] CMD_RX_NONE  = 3'd4;
   localparam logic [2:0] CMD_BURST    = 3'd5;
   localparam logic [2:0] CMD_RX_DONE  = 3'd6;

   typedef struct packed {
      logic [2:0]  code;
      logic [1:0]  flag;
      logic [10:0] id;
      logic [3:0]  len;
      logic [63:0] payload;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  mosi_byte;
      logic        cs_release;
      logic        needs_response;
      logic        tx_queued;
      logic        rx_valid;
      logic [10:0] rx_id;
      logic [3:0]  rx_len;
      logic [63:0] rx_payload;
      logic        last;
   } beat_type;

endpackage

FILE: hdl/cancs_front.sv
// Front end: tracks the exchange phase, captures bytes and issues commands.
module cancs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           req_type,
   input  logic [10:0]          frame_id,
   input  logic [7:0]           frame_len,
   input  logic [63:0]          frame_payload,
   input  logic [7:0]           miso_byte,
   output logic                 cmd_valid,
   output cancs_pkg::cmd_type   cmd
);
   import cancs_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_TXCTRL = 2'd1;
   localparam logic [1:0] PH_INTF   = 2'd2;
   localparam logic [1:0] PH_BURST  = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [10:0] pend_id_ff, pend_id_in;
   logic [3:0]  pend_len_ff, pend_len_in;
   logic [63:0] pend_pay_ff, pend_pay_in;
   logic [1:0]  flag_ff, flag_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  bytes_ff [BURST_LEN];

   logic [7:0]  last_bytes [BURST_LEN];
   logic [3:0]  dlc;
   logic [63:0] rx_pay;

   always_comb begin
      for (int k = 0; k < BURST_LEN - 1; k++) begin
         last_bytes[k] = bytes_ff[k];
      end
      last_bytes[BURST_LEN-1] = miso_byte;
      dlc = (last_bytes[4][3:0] > 4'd8) ? 4'd8 : last_bytes[4][3:0];
      for (int k = 0; k < 8; k++) begin
         rx_pay[8*k +: 8] = (4'(k) < dlc) ? last_bytes[5+k] : 8'h00;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      pend_id_in  = pend_id_ff;
      pend_len_in = pend_len_ff;
      pend_pay_in = pend_pay_ff;
      flag_in     = flag_ff;
      count_in    = count_ff;
      cmd_valid   = 1'b0;
      cmd         = '0;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_type == REQ_SEND) begin
                  pend_id_in  = frame_id;
                  pend_len_in = (frame_len > 8'd8) ? 4'd8 : frame_len[3:0];
                  pend_pay_in = frame_payload;
                  cmd_valid   = 1'b1;
                  cmd.code    = CMD_TX_READ;
                  phase_in    = PH_TXCTRL;
               end else if (req_type == REQ_POLL) begin
                  cmd_valid = 1'b1;
                  cmd.code  = CMD_RX_READ;
                  phase_in  = PH_INTF;
               end
            end
            PH_TXCTRL: begin
               if (req_type == REQ_BYTE) begin
                  cmd_valid = 1'b1;
                  if (miso_byte[TXREQ_BIT]) begin
                     cmd.code = CMD_TX_BUSY;
                  end else begin
                     cmd.code    = CMD_TX_WRITE;
                     cmd.id      = pend_id_ff;
                     cmd.len     = pend_len_ff;
                     cmd.payload = pend_pay_ff;
                  end
                  phase_in = PH_IDLE;
               end
            end
            PH_INTF: begin
               if (req_type == REQ_BYTE) begin
                  cmd_valid = 1'b1;
                  if (miso_byte[1:0] == 2'b00) begin
                     cmd.code = CMD_RX_NONE;
                     phase_in = PH_IDLE;
                  end else begin
                     flag_in  = miso_byte[0] ? 2'd1 : 2'd2;
                     cmd.code = CMD_BURST;
                     cmd.flag = flag_in;
                     count_in = 4'd0;
                     phase_in = PH_BURST;
                  end
               end
            end
            PH_BURST: begin
               if (req_type == REQ_BYTE) begin
                  if (count_ff == 4'(BURST_LEN - 1)) begin
                     cmd_valid   = 1'b1;
                     cmd.code    = CMD_RX_DONE;
                     cmd.flag    = flag_ff;
                     cmd.id      = {last_bytes[0], last_bytes[1][7:5]};
                     cmd.len     = dlc;
                     cmd.payload = rx_pay;
                     count_in    = 4'd0;
                     phase_in    = PH_IDLE;
                  end else begin
                     count_in = count_ff + 4'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         pend_id_ff  <= '0;
         pend_len_ff <= '0;
         pend_pay_ff <= '0;
         flag_ff     <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         pend_id_ff  <= pend_id_in;
         pend_len_ff <= pend_len_in;
         pend_pay_ff <= pend_pay_in;
         flag_ff     <= flag_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_BURST && req_type == REQ_BYTE
          && count_ff < 4'(BURST_LEN)) begin
         bytes_ff[count_ff] <= miso_byte;
      end
   end

endmodule

FILE: hdl/cancs_queue.sv
// Short command queue between front and back.
module cancs_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  cancs_pkg::cmd_type   wr_cmd,
   output logic                 full,
   output logic                 rd_valid,
   output cancs_pkg::cmd_type   rd_cmd,
   input  logic                 rd_pop
);
   import cancs_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: hdl/cancs_back.sv
// Back end: expands commands to SPI bytes/results, a beat a cycle unless held.
module cancs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cancs_pkg::cmd_type   cmd,
   output logic                 cmd_pop,
   output logic                 empty,
   input  logic                 pop,
   output cancs_pkg::beat_type  beat
);
   import cancs_pkg::*;

   logic [4:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   beat_type   beat_ff, beat_in;
   logic [4:0] last_step;
   logic [4:0] data_end;
   logic [2:0] byte_idx;
   logic       load;

   assign data_end = 5'd7 + 5'(cmd.len);
   assign byte_idx = 3'(step_ff - 5'd7);

   always_comb begin
      case (cmd.code)
         CMD_TX_READ:  last_step = 5'd2;
         CMD_RX_READ:  last_step = 5'd2;
         CMD_TX_WRITE: last_step = data_end + 5'd1;
         CMD_BURST:    last_step = 5'(BURST_LEN);
         CMD_RX_DONE:  last_step = 5'd4;
         default:      last_step = 5'd0;
      endcase
   end

   always_comb begin
      beat_in      = '0;
      beat_in.last = (step_ff == last_step);
      case (cmd.code)
         CMD_TX_READ, CMD_RX_READ: begin
            case (step_ff)
               5'd0:    beat_in.mosi_byte = INS_READ;
               5'd1:    beat_in.mosi_byte = (cmd.code == CMD_TX_READ) ? REG_TXCTRL : REG_INTF;
               default: begin
                  beat_in.cs_release     = 1'b1;
                  beat_in.needs_response = 1'b1;
               end
            endcase
         end
         CMD_TX_BUSY: begin
            beat_in.out_kind = KIND_TX;
         end
         CMD_TX_WRITE: begin
            if (step_ff == 5'd0) begin
               beat_in.mosi_byte = INS_WRITE;
            end else if (step_ff == 5'd1) begin
               beat_in.mosi_byte = REG_TXSIDH;
            end else if (step_ff == 5'd2) begin
               beat_in.mosi_byte = cmd.id[10:3];
            end else if (step_ff == 5'd3) begin
               beat_in.mosi_byte = {cmd.id[2:0], 5'b00000};
            end else if (step_ff == 5'd6) begin
               beat_in.mosi_byte  = {4'h0, cmd.len};
               beat_in.cs_release = (cmd.len == 4'd0);
            end else if (step_ff > 5'd6 && step_ff < data_end) begin
               beat_in.mosi_byte  = cmd.payload[8*byte_idx +: 8];
               beat_in.cs_release = (step_ff + 5'd1 == data_end);
            end else if (step_ff == data_end) begin
               beat_in.mosi_byte  = INS_RTS0;
               beat_in.cs_release = 1'b1;
            end else if (step_ff > data_end) begin
               beat_in.out_kind  = KIND_TX;
               beat_in.tx_queued = 1'b1;
            end
         end
         CMD_RX_NONE: begin
            beat_in.out_kind = KIND_RX;
         end
         CMD_BURST: begin
            if (step_ff == 5'd0) begin
               beat_in.mosi_byte = (cmd.flag == 2'd1) ? INS_RXB0 : INS_RXB1;
            end else begin
               beat_in.needs_response = 1'b1;
               beat_in.cs_release     = (step_ff == 5'(BURST_LEN));
            end
         end
         CMD_RX_DONE: begin
            case (step_ff)
               5'd0:    beat_in.mosi_byte = INS_BITMOD;
               5'd1:    beat_in.mosi_byte = REG_INTF;
               5'd2:    beat_in.mosi_byte = {6'd0, cmd.flag};
               5'd3:    beat_in.cs_release = 1'b1;
               default: begin
                  beat_in.out_kind   = KIND_RX;
                  beat_in.rx_valid   = 1'b1;
                  beat_in.rx_id      = cmd.id;
                  beat_in.rx_len     = cmd.len;
                  beat_in.rx_payload = cmd.payload;
               end
            endcase
         end
         default: begin
            beat_in = '0;
         end
      endcase
   end

   assign load    = cmd_valid && (!out_valid_ff || pop);
   assign cmd_pop = load && (step_ff == last_step);
   assign empty   = !out_valid_ff;
   assign beat    = beat_ff;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         step_in      = cmd_pop ? 5'd0 : step_ff + 5'd1;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

endmodule

FILE: hdl/can_controller_spi_frame_sequencer.sv
// Top level of the CAN controller SPI frame sequencer.
// The front end takes one request beat per cycle while its command queue has
// room; ignored beats are taken and produce nothing. The back end issues one
// result beat per cycle from the head command into the output register while
// that register is empty or being popped. A command has 1 result beat for a
// busy or empty answer, 3 for a status read, 5 for a receive completion, 14
// for a burst read and 9 to 17 for a frame send, 17 with a full payload.
// Sustained rate is set by the back end's one beat per cycle when pop keeps up.
module can_controller_spi_frame_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [10:0] req_frame_id,
   input  logic [7:0]  req_frame_len,
   input  logic [63:0] req_frame_payload,
   input  logic [7:0]  req_miso_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_cs_release,
   output logic        rsp_needs_response,
   output logic        rsp_tx_queued,
   output logic        rsp_rx_valid,
   output logic [10:0] rsp_rx_id,
   output logic [3:0]  rsp_rx_len,
   output logic [63:0] rsp_rx_payload,
   output logic        rsp_last
);
   import cancs_pkg::*;

   logic     accept;
   logic     fq_valid;
   cmd_type  fq_cmd;
   logic     qb_valid;
   cmd_type  qb_cmd;
   logic     qb_pop;
   beat_type beat;

   assign accept = push && !full;

   cancs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .frame_id      (req_frame_id),
      .frame_len     (req_frame_len),
      .frame_payload (req_frame_payload),
      .miso_byte     (req_miso_byte),
      .cmd_valid     (fq_valid),
      .cmd           (fq_cmd)
   );

   cancs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_cmd   (fq_cmd),
      .full     (full),
      .rd_valid (qb_valid),
      .rd_cmd   (qb_cmd),
      .rd_pop   (qb_pop)
   );

   cancs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd       (qb_cmd),
      .cmd_pop   (qb_pop),
      .empty     (empty),
      .pop       (pop),
      .beat      (beat)
   );

   assign rsp_out_kind       = beat.out_kind;
   assign rsp_mosi_byte      = beat.mosi_byte;
   assign rsp_cs_release     = beat.cs_release;
   assign rsp_needs_response = beat.needs_response;
   assign rsp_tx_queued      = beat.tx_queued;
   assign rsp_rx_valid       = beat.rx_valid;
   assign rsp_rx_id          = beat.rx_id;
   assign rsp_rx_len         = beat.rx_len;
   assign rsp_rx_payload     = beat.rx_payload;
   assign rsp_last           = beat.last;

endmodule
